// ===== sv/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

  // operand width of the datapath; port fields stay 32 bits
  localparam int KEY_BITS  = 32;
  localparam int FIELD_W   = 32;
  localparam int CNT_W     = $clog2(KEY_BITS);

  typedef logic [FIELD_W-1:0]  word_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [KEY_BITS+1:0] wide_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_PUB_EXP  = 2'd1,
    CFG_PRIV_EXP = 2'd2
  } cfg_idx_t;

  // operand pairs of the modular multiplier
  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_SQUARE,
    MUL_BASE
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     exp_shift;
    logic     res_cap;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic m_small;
    logic mul_done;
    logic exp_bit;
    logic exp_last;
  } dp_sts_t;

endpackage

// ===== sv/mexp_in_if.sv =====
`timescale 1ns / 1ps

interface mexp_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  mexp_pkg::word_t      value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

// ===== sv/mexp_out_if.sv =====
`timescale 1ns / 1ps

interface mexp_out_if;
  logic                 valid;
  logic                 ready;
  mexp_pkg::word_t      result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// ===== sv/mexp_cfg_if.sv =====
`timescale 1ns / 1ps

interface mexp_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           index;
  mexp_pkg::word_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/mexp_dp.sv =====
`timescale 1ns / 1ps

module mexp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_pkg::dp_cmd_t   cmd,
  output mexp_pkg::dp_sts_t   sts,
  input  logic                in_func,
  input  mexp_pkg::word_t     in_value,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  mexp_pkg::word_t     cfg_data,
  output logic                cfg_ready,
  output mexp_pkg::word_t     result
);

  // configuration registers
  mexp_pkg::word_t modulus_r;
  mexp_pkg::word_t pub_exp_r;
  mexp_pkg::word_t priv_exp_r;

  // exponentiation registers
  mexp_pkg::key_t  value_r;
  mexp_pkg::key_t  base_r;
  mexp_pkg::key_t  acc_r;
  mexp_pkg::key_t  exp_r;
  mexp_pkg::cnt_t  ecnt_r;
  mexp_pkg::word_t res_r;

  // multiplier registers
  mexp_pkg::key_t     ma_r;
  mexp_pkg::key_t     mb_r;
  mexp_pkg::key_t     mp_r;
  mexp_pkg::cnt_t     mcnt_r;
  logic               mbusy_r;
  mexp_pkg::mul_sel_t msel_r;

  mexp_pkg::key_t  m_key;
  mexp_pkg::wide_t m1;
  mexp_pkg::wide_t m2;
  mexp_pkg::wide_t sum;
  mexp_pkg::wide_t stepw;
  mexp_pkg::key_t  step;

  assign cfg_ready = 1'b1;
  assign m_key     = mexp_pkg::key_t'(modulus_r);

  // configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= mexp_pkg::word_t'(2);
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mexp_pkg::CFG_MODULUS:  modulus_r  <= cfg_data;
        mexp_pkg::CFG_PUB_EXP:  pub_exp_r  <= cfg_data;
        mexp_pkg::CFG_PRIV_EXP: priv_exp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // one multiplier bit per cycle: acc = (2*acc + bit*a) mod m, below 3m before correction
  always_comb begin
    m1  = mexp_pkg::wide_t'(m_key);
    m2  = mexp_pkg::wide_t'({m_key, 1'b0});
    sum = mexp_pkg::wide_t'({mp_r, 1'b0})
        + (mb_r[mexp_pkg::KEY_BITS-1] ? mexp_pkg::wide_t'(ma_r) : '0);
    if (sum >= m2) begin
      stepw = sum - m2;
    end else if (sum >= m1) begin
      stepw = sum - m1;
    end else begin
      stepw = sum;
    end
    step = mexp_pkg::key_t'(stepw);
  end

  // multiplier sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
    end else if (mbusy_r && mcnt_r == '0) begin
      mbusy_r <= 1'b0;
    end
  end

  // multiplier operands and partial product
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      unique case (cmd.mul_sel)
        mexp_pkg::MUL_REDUCE: begin
          ma_r <= mexp_pkg::key_t'(1);
          mb_r <= value_r;
        end
        mexp_pkg::MUL_SQUARE: begin
          ma_r <= acc_r;
          mb_r <= acc_r;
        end
        default: begin
          ma_r <= base_r;
          mb_r <= acc_r;
        end
      endcase
      msel_r <= cmd.mul_sel;
      mp_r   <= '0;
      mcnt_r <= mexp_pkg::cnt_t'(mexp_pkg::KEY_BITS - 1);
    end else if (mbusy_r) begin
      mp_r   <= step;
      mb_r   <= {mb_r[mexp_pkg::KEY_BITS-2:0], 1'b0};
      mcnt_r <= mcnt_r - mexp_pkg::cnt_t'(1);
    end
  end

  // item capture, product write-back and exponent scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= mexp_pkg::key_t'(in_value);
      exp_r   <= in_func ? mexp_pkg::key_t'(priv_exp_r) : mexp_pkg::key_t'(pub_exp_r);
      ecnt_r  <= mexp_pkg::cnt_t'(mexp_pkg::KEY_BITS - 1);
      acc_r   <= mexp_pkg::key_t'(1);
    end else begin
      if (mbusy_r && mcnt_r == '0) begin
        if (msel_r == mexp_pkg::MUL_REDUCE) begin
          base_r <= step;
        end else begin
          acc_r <= step;
        end
      end
      if (cmd.exp_shift) begin
        exp_r  <= {exp_r[mexp_pkg::KEY_BITS-2:0], 1'b0};
        ecnt_r <= ecnt_r - mexp_pkg::cnt_t'(1);
      end
    end
  end

  // result register, zero for a modulus below two
  always_ff @(posedge clk) begin
    if (cmd.res_cap) begin
      res_r <= sts.m_small ? '0 : mexp_pkg::word_t'(acc_r);
    end
  end

  assign result       = res_r;
  assign sts.m_small  = m_key < mexp_pkg::key_t'(2);
  assign sts.mul_done = mbusy_r && mcnt_r == '0;
  assign sts.exp_bit  = exp_r[mexp_pkg::KEY_BITS-1];
  assign sts.exp_last = ecnt_r == '0;

endmodule

// ===== sv/mexp_ctrl.sv =====
`timescale 1ns / 1ps

module mexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mexp_pkg::dp_cmd_t   cmd,
  input  mexp_pkg::dp_sts_t   sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_W,
    ST_SQ,
    ST_SQ_W,
    ST_MB,
    ST_MB_W,
    ST_NEXT,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = mexp_pkg::MUL_SQUARE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.m_small ? ST_DONE : ST_RED;
        end
      end
      ST_RED: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mexp_pkg::MUL_REDUCE;
        state_nxt     = ST_RED_W;
      end
      ST_RED_W: begin
        if (sts.mul_done) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mexp_pkg::MUL_SQUARE;
        state_nxt     = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (sts.mul_done) begin
          state_nxt = sts.exp_bit ? ST_MB : ST_NEXT;
        end
      end
      ST_MB: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mexp_pkg::MUL_BASE;
        state_nxt     = ST_MB_W;
      end
      ST_MB_W: begin
        if (sts.mul_done) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.exp_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.exp_shift = 1'b1;
          state_nxt     = ST_SQ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.res_cap = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.res_cap) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// channel   dir   payload                       handshake
// in_if     in    func, value[31:0]             valid / ready
// out_if    out   result[31:0]                  valid / ready
// cfg_if    in    index[1:0], data[31:0]        valid / ready (ready always high)
//
// one word at a time: a reduction of the value, then for each of the KEY_BITS exponent bits,
// MSB first, a square and, for a set bit, a multiply by the base, each on the bit-serial
// modular multiplier, one multiplier bit per cycle; a modulus below two skips these and gives result 0
// reset (rst_n, synchronous) clears the sequencer and loads modulus 2, exponents 0
// a finished word waits in the output register; a new input word is taken while it waits

module modular_exponentiation (
  input  logic       clk,
  input  logic       rst_n,
  mexp_in_if.sink    in_if,
  mexp_out_if.source out_if,
  mexp_cfg_if.sink   cfg_if
);

  mexp_pkg::dp_cmd_t cmd;
  mexp_pkg::dp_sts_t sts;

  // sequencer
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // registers and modular multiplier
  mexp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_if.func),
    .in_value  (in_if.value),
    .cfg_valid (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .cfg_ready (cfg_if.ready),
    .result    (out_if.result)
  );

endmodule
